@@ design/vpfb_pkg.sv @@
// Shared types and constants for the voice playout frame buffer.
`timescale 1ns / 1ps

package vpfb_pkg;

   localparam int unsigned BUFFER_BYTES_DEF = 4096;
   localparam int unsigned FRAME_BYTES_DEF  = 160;
   localparam int unsigned QUEUE_DEPTH      = 2;

   localparam logic [7:0] SILENCE_BYTE = 8'hd5;

   // Configuration register indexes.
   localparam logic [1:0] CSR_PAYLOAD_TYPE    = 2'd0;
   localparam logic [1:0] CSR_STREAM_ID       = 2'd1;
   localparam logic [1:0] CSR_START_SEQUENCE  = 2'd2;
   localparam logic [1:0] CSR_START_TIMESTAMP = 2'd3;

   typedef enum logic [1:0] {
      REQ_PUSH   = 2'd0,
      REQ_PULL   = 2'd1,
      REQ_CLEAR  = 2'd2,
      REQ_UNUSED = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_PULL  = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      PHASE_IDLE   = 2'd0,
      PHASE_ACCEPT = 2'd1,
      PHASE_DROP   = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE    = 3'd0,
      ST_PAD     = 3'd1,
      ST_ISSUE   = 3'd2,
      ST_CAPTURE = 3'd3,
      ST_EMIT    = 3'd4
   } back_state_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] stream_source;
      logic [7:0]  data_byte;
      logic [12:0] payload_length;
      logic        last_byte;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] sequence_out;
      logic [31:0] timestamp_out;
      logic [6:0]  payload_type_out;
      logic [31:0] stream_id_out;
      logic [31:0] frame_word;
      logic        is_silence;
      logic        last_word;
   } rsp_payload_type;

   // Classified request as it travels from the front part to the back part.
   typedef struct packed {
      op_type      op;
      logic [31:0] source;
      logic [7:0]  data;
      logic [12:0] length;
      logic        last;
   } cmd_type;

   typedef struct packed {
      logic        seq_load;
      logic [15:0] seq_value;
      logic        ts_load;
      logic [31:0] ts_value;
   } cfg_load_type;

   typedef struct packed {
      logic [6:0]  ptype;
      logic [31:0] stream_id;
   } cfg_stamp_type;

endpackage

@@ design/voice_playout_frame_buffer_top.sv @@
// Top level of the voice playout frame buffer: register port and part wiring.
//
//   port group   direction  handshake                 contents
//   req_*        in         req_valid / req_stall     push byte, pull frame, clear
//   rsp_*        out        rsp_valid / rsp_stall     one 32-bit frame word per item
//   p* (APB)     in/out     psel, penable, pready     four configuration registers
//
// A push or clear request is handled by the back part in its idle state; the last byte of an
// accepted payload then pads the store with silence bytes up to a frame boundary or its end.
// A pull reads the frame word by word through the byte-wide read port of the store:
// four reads and one capture per word, then the word is emitted.
// Reset is synchronous; the store needs no clearing pass and is usable at once.
// A stalled result holds only the back part; the two-entry request queue keeps
// taking requests until it fills.
`timescale 1ns / 1ps

module voice_playout_frame_buffer_top #(
   parameter int unsigned BUFFER_BYTES = vpfb_pkg::BUFFER_BYTES_DEF,
   parameter int unsigned FRAME_BYTES  = vpfb_pkg::FRAME_BYTES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  vpfb_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output vpfb_pkg::rsp_payload_type rsp_payload,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [3:0]                paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);
   import vpfb_pkg::*;

   logic [6:0]    ptype_ff, ptype_in;
   logic [31:0]   sid_ff, sid_in;
   logic [15:0]   sseq_ff, sseq_in;
   logic [31:0]   sts_ff, sts_in;
   logic          csr_write;
   logic [1:0]    csr_index;
   cfg_load_type  cfg_load;
   cfg_stamp_type cfg_stamp;
   logic          cmd_valid;
   cmd_type       cmd;
   logic          cmd_take;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[3:2];

   always_comb begin
      ptype_in = ptype_ff;
      sid_in   = sid_ff;
      sseq_in  = sseq_ff;
      sts_in   = sts_ff;
      cfg_load = '0;
      cfg_load.seq_value = pwdata[15:0];
      cfg_load.ts_value  = pwdata;
      if (csr_write) begin
         case (csr_index)
            CSR_PAYLOAD_TYPE:   ptype_in = pwdata[6:0];
            CSR_STREAM_ID:      sid_in   = pwdata;
            CSR_START_SEQUENCE: begin
               sseq_in           = pwdata[15:0];
               cfg_load.seq_load = 1'b1;
            end
            CSR_START_TIMESTAMP: begin
               sts_in           = pwdata;
               cfg_load.ts_load = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_PAYLOAD_TYPE:    prdata = {25'd0, ptype_ff};
         CSR_STREAM_ID:       prdata = sid_ff;
         CSR_START_SEQUENCE:  prdata = {16'd0, sseq_ff};
         CSR_START_TIMESTAMP: prdata = sts_ff;
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptype_ff <= 7'd8;
         sid_ff   <= '0;
         sseq_ff  <= '0;
         sts_ff   <= '0;
      end else begin
         ptype_ff <= ptype_in;
         sid_ff   <= sid_in;
         sseq_ff  <= sseq_in;
         sts_ff   <= sts_in;
      end
   end

   assign cfg_stamp.ptype     = ptype_ff;
   assign cfg_stamp.stream_id = sid_ff;

   vpfb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_take    (cmd_take)
   );

   vpfb_back #(
      .BUFFER_BYTES (BUFFER_BYTES),
      .FRAME_BYTES  (FRAME_BYTES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_take    (cmd_take),
      .cfg_load    (cfg_load),
      .cfg_stamp   (cfg_stamp),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ design/vpfb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module vpfb_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/vpfb_front.sv @@
// Front part: accepts requests, classifies them and queues them for the back part.
`timescale 1ns / 1ps

module vpfb_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  vpfb_pkg::req_payload_type req_payload,
   output logic                     cmd_valid,
   output vpfb_pkg::cmd_type        cmd,
   input  logic                     cmd_take
);
   import vpfb_pkg::*;

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type          entry_ff [QUEUE_DEPTH];
   cmd_type          entry_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             accept;
   logic             enq;
   logic             deq;

   assign req_stall = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;
   assign cmd_valid = (count_ff != '0);
   assign cmd       = entry_ff[rd_ptr_ff];
   assign deq       = cmd_take && cmd_valid;

   // The unused request code is dropped here and never reaches the back part.
   always_comb begin
      entry_in.source = req_payload.stream_source;
      entry_in.data   = req_payload.data_byte;
      entry_in.length = req_payload.payload_length;
      entry_in.last   = req_payload.last_byte;
      entry_in.op     = OP_PUSH;
      enq             = 1'b0;
      case (req_code_type'(req_payload.req_type))
         REQ_PUSH: begin
            entry_in.op = OP_PUSH;
            enq         = accept;
         end
         REQ_PULL: begin
            entry_in.op = OP_PULL;
            enq         = accept;
         end
         REQ_CLEAR: begin
            entry_in.op = OP_CLEAR;
            enq         = accept;
         end
         default: begin
            enq = 1'b0;
         end
      endcase
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (enq) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (deq) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (enq && !deq) begin
         count_in = count_ff + 1'b1;
      end else if (deq && !enq) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         entry_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

@@ design/vpfb_back.sv @@
// Back part: byte store, padding, frame readout and the result register.
`timescale 1ns / 1ps

module vpfb_back #(
   parameter int unsigned BUFFER_BYTES = vpfb_pkg::BUFFER_BYTES_DEF,
   parameter int unsigned FRAME_BYTES  = vpfb_pkg::FRAME_BYTES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     cmd_valid,
   input  vpfb_pkg::cmd_type        cmd,
   output logic                     cmd_take,
   input  vpfb_pkg::cfg_load_type   cfg_load,
   input  vpfb_pkg::cfg_stamp_type  cfg_stamp,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output vpfb_pkg::rsp_payload_type rsp_payload
);
   import vpfb_pkg::*;

   localparam int unsigned ADDR_W = $clog2(BUFFER_BYTES);
   localparam int unsigned PTR_W  = $clog2(BUFFER_BYTES + 1);
   localparam int unsigned LEN_W  = 13;
   localparam int unsigned SUM_W  = ((PTR_W > LEN_W) ? PTR_W : LEN_W) + 1;
   localparam int unsigned LIMIT  = BUFFER_BYTES - FRAME_BYTES;
   localparam int unsigned OFFS_W = $clog2(FRAME_BYTES);
   localparam int unsigned WORDS  = (FRAME_BYTES + 3) / 4;
   localparam int unsigned POS_W  = $clog2(WORDS * 4);
   localparam int unsigned WCNT_W = $clog2(WORDS);

   back_state_type    state_ff, state_in;
   phase_type         phase_ff, phase_in;
   logic [PTR_W-1:0]  wp_ff, wp_in;
   logic [PTR_W-1:0]  rp_ff, rp_in;
   logic [OFFS_W-1:0] offs_ff, offs_in;
   logic [31:0]       held_ff, held_in;
   logic [15:0]       seq_ff, seq_in;
   logic [31:0]       ts_ff, ts_in;
   logic              have_ff, have_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [1:0]        k_ff, k_in;
   logic [WCNT_W-1:0] wcnt_ff, wcnt_in;
   logic              rd_pend_ff, rd_pend_in;
   logic              rd_inrange_ff, rd_inrange_in;
   logic [31:0]       shift_ff, shift_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_ff, rsp_in;

   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [7:0]        ram_wr_data;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [7:0]        ram_rd_data;

   // Push decision and readout signals.
   logic              phase_open;
   logic              src_switch;
   logic [PTR_W-1:0]  wp0;
   logic [PTR_W-1:0]  rp0;
   logic [OFFS_W-1:0] offs0;
   logic              overflow;
   phase_type         phase_eff;
   logic              push_write;
   logic              pad_go;
   logic              pad_en;
   logic              out_free;
   logic              word_last;
   logic [PTR_W-1:0]  rp_next_frame;
   logic [7:0]        cap_byte;

   function automatic logic [OFFS_W-1:0] offs_inc(input logic [OFFS_W-1:0] o);
      offs_inc = (o == OFFS_W'(FRAME_BYTES - 1)) ? '0 : o + 1'b1;
   endfunction

   vpfb_ram #(
      .WIDTH (8),
      .DEPTH (BUFFER_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign cmd_take = (state_ff == ST_IDLE) && cmd_valid;

   // The source check and the overflow decision happen on the first byte only.
   assign phase_open = (phase_ff == PHASE_IDLE);
   assign src_switch = phase_open && (wp_ff != '0) && (held_ff != cmd.source);
   assign wp0        = src_switch ? '0 : wp_ff;
   assign rp0        = src_switch ? '0 : rp_ff;
   assign offs0      = src_switch ? '0 : offs_ff;
   assign overflow   = (SUM_W'(wp0) + SUM_W'(cmd.length)) > SUM_W'(LIMIT);
   assign phase_eff  = phase_open ? (overflow ? PHASE_DROP : PHASE_ACCEPT) : phase_ff;
   assign push_write = (phase_eff == PHASE_ACCEPT) && (wp0 < PTR_W'(LIMIT));
   assign pad_go     = cmd.last && (phase_eff == PHASE_ACCEPT);
   assign pad_en     = (offs_ff != '0) && (wp_ff < PTR_W'(BUFFER_BYTES));

   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign word_last     = (wcnt_ff == WCNT_W'(WORDS - 1));
   assign rp_next_frame = rp_ff + PTR_W'(FRAME_BYTES);
   assign cap_byte      = !rd_inrange_ff ? 8'h00 : (have_ff ? ram_rd_data : SILENCE_BYTE);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd.op)
                  OP_PUSH:  state_in = pad_go ? ST_PAD : ST_IDLE;
                  OP_PULL:  state_in = ST_ISSUE;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_PAD: begin
            if (!pad_en) begin
               state_in = ST_IDLE;
            end
         end
         ST_ISSUE: begin
            if (k_ff == 2'd3) begin
               state_in = ST_CAPTURE;
            end
         end
         ST_CAPTURE: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = word_last ? ST_IDLE : ST_ISSUE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      phase_in      = phase_ff;
      wp_in         = wp_ff;
      rp_in         = rp_ff;
      offs_in       = offs_ff;
      held_in       = held_ff;
      seq_in        = seq_ff;
      ts_in         = ts_ff;
      have_in       = have_ff;
      pos_in        = pos_ff;
      k_in          = k_ff;
      wcnt_in       = wcnt_ff;
      rd_pend_in    = 1'b0;
      rd_inrange_in = rd_inrange_ff;
      shift_in      = rd_pend_ff ? {shift_ff[23:0], cap_byte} : shift_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = wp_ff[ADDR_W-1:0];
      ram_wr_data   = SILENCE_BYTE;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = rp_ff[ADDR_W-1:0] + ADDR_W'(pos_ff);

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd.op)
                  OP_PUSH: begin
                     if (phase_open) begin
                        held_in = cmd.source;
                     end
                     wp_in   = wp0;
                     rp_in   = rp0;
                     offs_in = offs0;
                     if (push_write) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = wp0[ADDR_W-1:0];
                        ram_wr_data = cmd.data;
                        wp_in       = wp0 + 1'b1;
                        offs_in     = offs_inc(offs0);
                     end
                     phase_in = cmd.last ? PHASE_IDLE : phase_eff;
                  end
                  OP_PULL: begin
                     have_in = (wp_ff >= rp_ff) && ((wp_ff - rp_ff) >= PTR_W'(FRAME_BYTES));
                     seq_in  = seq_ff + 1'b1;
                     ts_in   = ts_ff + 32'(FRAME_BYTES);
                     pos_in  = '0;
                     k_in    = '0;
                     wcnt_in = '0;
                  end
                  default: begin
                     wp_in   = '0;
                     rp_in   = '0;
                     offs_in = '0;
                     if (phase_ff == PHASE_ACCEPT) begin
                        phase_in = PHASE_DROP;
                     end
                  end
               endcase
            end
         end
         ST_PAD: begin
            if (pad_en) begin
               ram_wr_en = 1'b1;
               wp_in     = wp_ff + 1'b1;
               offs_in   = offs_inc(offs_ff);
            end
         end
         ST_ISSUE: begin
            ram_rd_en     = 1'b1;
            rd_pend_in    = 1'b1;
            rd_inrange_in = {1'b0, pos_ff} < (POS_W + 1)'(FRAME_BYTES);
            pos_in        = pos_ff + 1'b1;
            k_in          = k_ff + 1'b1;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_in.sequence_out     = seq_ff;
               rsp_in.timestamp_out    = ts_ff;
               rsp_in.payload_type_out = cfg_stamp.ptype;
               rsp_in.stream_id_out    = cfg_stamp.stream_id;
               rsp_in.frame_word       = shift_ff;
               rsp_in.is_silence       = !have_ff;
               rsp_in.last_word        = word_last;
               wcnt_in                 = wcnt_ff + 1'b1;
               // Once the frame is read out, an emptied store drops back to zero.
               if (word_last && have_ff) begin
                  if (rp_next_frame >= wp_ff) begin
                     rp_in   = '0;
                     wp_in   = '0;
                     offs_in = '0;
                  end else begin
                     rp_in = rp_next_frame;
                  end
               end
            end
         end
         default: begin
         end
      endcase

      if (cfg_load.seq_load) begin
         seq_in = cfg_load.seq_value;
      end
      if (cfg_load.ts_load) begin
         ts_in = cfg_load.ts_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PHASE_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         offs_ff      <= '0;
         held_ff      <= '0;
         seq_ff       <= '0;
         ts_ff        <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         offs_ff      <= offs_in;
         held_ff      <= held_in;
         seq_ff       <= seq_in;
         ts_ff        <= ts_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      have_ff       <= have_in;
      pos_ff        <= pos_in;
      k_ff          <= k_in;
      wcnt_ff       <= wcnt_in;
      rd_inrange_ff <= rd_inrange_in;
      shift_ff      <= shift_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef NO_ASSERTIONS
   a_ptr_order: assert property (@(posedge clock) disable iff (reset)
      rp_ff <= wp_ff)
      else $error("read index passed write index");

   a_wp_bound: assert property (@(posedge clock) disable iff (reset)
      wp_ff <= PTR_W'(BUFFER_BYTES))
      else $error("write index beyond the store");

   a_offs_empty: assert property (@(posedge clock) disable iff (reset)
      (wp_ff == '0) |-> (offs_ff == '0))
      else $error("frame offset not zero with an empty store");

   a_pad_between: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PAD) |-> (phase_ff == PHASE_IDLE))
      else $error("padding while a payload is still open");

   a_port_conflict: assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en))
      else $error("store written and read in one cycle");
`endif

endmodule
